/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/drpb_pkg.sv */
// Package for the descriptor ring packet buffer.
// Types and constants; no dependencies.
package drpb_pkg;
  localparam int SLOTS     = 64;
  localparam int AREA_SIZE = 131072;
  localparam int IW        = $clog2(SLOTS);
  localparam int OW        = $clog2(AREA_SIZE);
  localparam int LW        = OW + 1;
  localparam int EW        = 7;

  typedef enum logic [2:0] {
    CMD_WSTART = 3'd0, CMD_WFINISH = 3'd1, CMD_RSTART = 3'd2,
    CMD_RFINISH = 3'd3, CMD_INVAL = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_REFUSED = 2'd1, ST_INVAL = 2'd2
  } status_t;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_OUT} state_t;

  typedef enum logic [0:0] {REG_AREA = 1'b0, REG_ENTRIES = 1'b1} reg_idx_t;

  typedef struct packed {
    logic rd;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic busy;
  } sts_t;
endpackage

/* rtl/drpb_if.sv */
// Valid/ready channel interface for items.
// Depends on nothing; payload widths are fixed.
interface drpb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [17:0] byte_count;
  modport source (output valid, command, byte_count, input ready);
  modport sink (input valid, command, byte_count, output ready);
endinterface

interface drpb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [16:0] offset;
  logic [17:0] length;
  logic        ring_empty;
  modport source (output valid, status, offset, length, ring_empty, input ready);
  modport sink (input valid, status, offset, length, ring_empty, output ready);
endinterface

/* rtl/descriptor_ring_packet_buffer_unit.sv */
// Descriptor ring packet buffer, top level.
// An item passes through the read, execute and output states; in the read state an
// index that exceeds the slots in use is first reduced by subtraction (up to 31 steps).
// One item at a time: a new item is accepted only in the idle state, which is
// reached again once the result of the last item is taken.
// Reset (rst, synchronous) empties the ring and restores register defaults.
`include "assert_macros.svh"
module descriptor_ring_packet_buffer_unit (
  input  logic          clk,
  input  logic          rst,
  drpb_in_if.sink       in_ch,
  drpb_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [17:0]   cfg_data
);
  drpb_pkg::ctl_t ctl;
  drpb_pkg::sts_t sts;
  logic accept;
  assign accept = in_ch.valid && in_ch.ready;

  drpb_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .ctl
  );

  drpb_dp u_dp (
    .clk, .rst, .accept,
    .command(in_ch.command), .byte_count(in_ch.byte_count),
    .ctl, .sts, .cfg_we, .cfg_index, .cfg_data,
    .status(out_ch.status), .offset(out_ch.offset),
    .length(out_ch.length), .ring_empty(out_ch.ring_empty)
  );

  `ASSERT_IMPLIES(a_excl, out_ch.valid, !in_ch.ready)
  `ASSERT_NEXT(a_exec_out, ctl.exec, out_ch.valid)
  `ASSERT_IMPLIES(a_status, out_ch.valid, out_ch.status != 2'd3)
endmodule

/* rtl/drpb_ctrl.sv */
// Controller state machine: reduce indices, read descriptors, execute, present result.
// Depends on drpb_pkg.
module drpb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  drpb_pkg::sts_t       sts,
  output drpb_pkg::ctl_t       ctl
);
  drpb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= drpb_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      drpb_pkg::S_IDLE: if (in_valid) state_next = drpb_pkg::S_READ;
      drpb_pkg::S_READ: if (!sts.busy) state_next = drpb_pkg::S_EXEC;
      drpb_pkg::S_EXEC: state_next = drpb_pkg::S_OUT;
      drpb_pkg::S_OUT: if (out_ready) state_next = drpb_pkg::S_IDLE;
      default: state_next = drpb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    ctl = '0;
    unique case (state)
      drpb_pkg::S_IDLE: in_ready = 1'b1;
      drpb_pkg::S_READ: ctl.rd = 1'b1;
      drpb_pkg::S_EXEC: ctl.exec = 1'b1;
      drpb_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

/* rtl/drpb_dp.sv */
// Datapath: descriptor memories, ring indices, placement and result regs.
// Depends on drpb_pkg.
module drpb_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [2:0]            command,
  input  logic [17:0]           byte_count,
  input  drpb_pkg::ctl_t        ctl,
  output drpb_pkg::sts_t        sts,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [17:0]           cfg_data,
  output logic [1:0]            status,
  output logic [16:0]           offset,
  output logic [17:0]           length,
  output logic                  ring_empty
);
  localparam int IW = drpb_pkg::IW;
  localparam int OW = drpb_pkg::OW;
  localparam int LW = drpb_pkg::LW;

  logic [OW-1:0] mem_off [drpb_pkg::SLOTS];
  logic [LW-1:0] mem_res [drpb_pkg::SLOTS];
  logic [LW-1:0] mem_len [drpb_pkg::SLOTS];

  logic [17:0] area_bytes;
  logic [6:0]  ring_entries;
  logic [IW-1:0] read_index, write_index;
  logic [IW-1:0] rp, wp;
  logic write_pending, drop_request;
  logic [LW-1:0] read_held_length;
  logic [2:0]  cmd_r;
  logic [17:0] cnt_r;

  logic [OW-1:0] r_off, n_off;
  logic [LW-1:0] w_res, r_len, n_res;

  logic [IW:0] e;
  logic [LW-1:0] area;
  logic [IW-1:0] wp1, np;
  logic [IW:0] e_m1;
  logic [IW-1:0] rd_addr;

  always_comb begin
    if (ring_entries < 7'd2) e = (IW+1)'(2);
    else if (ring_entries > 7'(drpb_pkg::SLOTS)) e = (IW+1)'(drpb_pkg::SLOTS);
    else e = ring_entries[IW:0];
    area = (area_bytes > 18'(drpb_pkg::AREA_SIZE)) ? LW'(drpb_pkg::AREA_SIZE)
                                                    : area_bytes[LW-1:0];
    e_m1 = e - 1'b1;
    wp1 = ((IW+1)'(wp) == e_m1) ? '0 : wp + 1'b1;
    np  = (wp == '0) ? e_m1[IW-1:0] : wp - 1'b1;
  end

  logic [IW-1:0] rp1;
  assign rp1 = ((IW+1)'(rp) == e_m1) ? '0 : rp + 1'b1;

  // indices reduced modulo slots in use, one subtraction per cycle
  assign sts.busy = ((IW+1)'(rp) >= e) || ((IW+1)'(wp) >= e);

  always_ff @(posedge clk) begin
    if (accept) begin
      rp <= read_index;
      wp <= write_index;
    end else if (ctl.rd && sts.busy) begin
      if ((IW+1)'(rp) >= e) rp <= IW'((IW+1)'(rp) - e);
      if ((IW+1)'(wp) >= e) wp <= IW'((IW+1)'(wp) - e);
    end
  end

  // r_off holds the write slot offset for write_finish, else the read slot offset
  assign rd_addr = (cmd_r == drpb_pkg::CMD_WFINISH) ? wp : rp;

  // descriptor reads registered
  always_ff @(posedge clk) begin
    if (ctl.rd && !sts.busy) begin
      r_off <= mem_off[rd_addr];
      r_len <= mem_len[rp];
      w_res <= mem_res[wp];
      n_off <= mem_off[np];
      n_res <= mem_res[np];
    end
  end

  logic [LW:0] rsize;
  logic [LW+1:0] new_end, sum;
  logic place_ok;
  logic [OW-1:0] where;
  logic empty_now;
  assign empty_now = (rp == wp);

  always_comb begin
    rsize = ((LW+1)'(cnt_r) + (LW+1)'(63)) & ~(LW+1)'(63);
    new_end = (LW+2)'(n_off) + (LW+2)'(n_res);
    sum = new_end + (LW+2)'(rsize);
    place_ok = 1'b0;
    where = '0;
    if (empty_now) begin
      place_ok = (rsize <= (LW+1)'(area));
    end else if (wp1 == rp) begin
      place_ok = 1'b0;
    end else if (r_off <= n_off) begin
      if (sum < (LW+2)'(area)) begin
        place_ok = 1'b1; where = OW'(new_end);
      end else if (rsize < (LW+1)'(r_off)) begin
        place_ok = 1'b1;
      end
    end else if (sum < (LW+2)'(r_off)) begin
      place_ok = 1'b1; where = OW'(new_end);
    end
  end

  logic [LW-1:0] clamp;
  assign clamp = (LW'(cnt_r) > w_res) ? w_res : LW'(cnt_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= command;
      cnt_r <= byte_count;
    end
    if (ctl.exec) begin
      if (cmd_r == drpb_pkg::CMD_WSTART && cnt_r != '0 && place_ok) begin
        mem_off[wp] <= where;
        mem_res[wp] <= rsize[LW-1:0];
        mem_len[wp] <= '0;
      end else if (cmd_r == drpb_pkg::CMD_WFINISH && write_pending) begin
        mem_len[wp] <= clamp;
      end
    end
  end

  logic [IW-1:0] ri_n, wi_n, ri_mod, wi_mod;
  always_comb begin
    ri_n = read_index;
    wi_n = write_index;
    ri_mod = rp;
    wi_mod = wp;
    if (cmd_r == drpb_pkg::CMD_WFINISH && write_pending) begin
      wi_n = wp1;
      wi_mod = wp1;
    end
    if (cmd_r == drpb_pkg::CMD_RSTART && drop_request) begin
      ri_n = wp;
      ri_mod = wp;
    end
    if (cmd_r == drpb_pkg::CMD_RFINISH && read_held_length != '0) begin
      ri_n = rp1;
      ri_mod = rp1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_bytes <= 18'(drpb_pkg::AREA_SIZE);
      ring_entries <= 7'(drpb_pkg::SLOTS);
      read_index <= '0;
      write_index <= '0;
      write_pending <= 1'b0;
      drop_request <= 1'b0;
      read_held_length <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == drpb_pkg::REG_AREA) area_bytes <= cfg_data;
        else ring_entries <= cfg_data[6:0];
      end
      if (ctl.exec) begin
        read_index <= ri_n;
        write_index <= wi_n;
        status <= drpb_pkg::ST_REFUSED;
        offset <= '0;
        length <= '0;
        ring_empty <= (ri_mod == wi_mod);
        unique case (cmd_r)
          drpb_pkg::CMD_WSTART: if (cnt_r != '0) begin
            write_pending <= place_ok;
            if (place_ok) begin
              status <= drpb_pkg::ST_OK; offset <= where; length <= cnt_r;
            end
          end
          drpb_pkg::CMD_WFINISH: if (write_pending) begin
            write_pending <= 1'b0;
            status <= drpb_pkg::ST_OK; offset <= r_off; length <= clamp;
          end
          drpb_pkg::CMD_RSTART: begin
            if (drop_request) begin
              drop_request <= 1'b0; read_held_length <= '0;
              status <= drpb_pkg::ST_INVAL;
            end else if (empty_now) begin
              read_held_length <= '0;
            end else begin
              offset <= r_off; length <= r_len; read_held_length <= r_len;
              status <= drpb_pkg::ST_OK;
            end
          end
          drpb_pkg::CMD_RFINISH: if (read_held_length != '0) begin
            read_held_length <= '0; status <= drpb_pkg::ST_OK;
          end
          drpb_pkg::CMD_INVAL: begin
            drop_request <= 1'b1; status <= drpb_pkg::ST_OK;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
